// ----- hdl/gffa_pkg.sv -----
// ---------------------------------------------------------------------------
// gffa_pkg
// Shared types and constants of the grid first-fit rectangle allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gffa_pkg;

   localparam int FUNC_W      = 2;
   localparam int SIZE_W      = 5;
   localparam int PIVOT_W     = 4;
   localparam int CFG_W       = 5;
   localparam int CSR_INDEX_W = 1;

   localparam int DEF_MAX_COLUMNS = 16;
   localparam int DEF_MAX_ROWS    = 16;

   // request tdata: func, item_width, item_height, pivot_x, pivot_y
   localparam int REQ_FIELDS_W = FUNC_W + 2 * SIZE_W + 2 * PIVOT_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   // response tdata: ok, place_x, place_y
   localparam int RSP_FIELDS_W = 1 + 2 * PIVOT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 5'd10;
   localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 5'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FIRST_FIT = 2'd0,
      FUNC_ADD_AT    = 2'd1,
      FUNC_REMOVE    = 2'd2,
      FUNC_NOP       = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SCAN,
      OP_CHECK,
      OP_SET,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   src_pivot;
      logic   res_clear;
      logic   res_pivot;
      logic   rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     bad_size;
      logic     pos_fit;
      logic     busy;
      logic     found;
      logic     acc_zero;
      logic     rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/gffa_dp.sv -----
// ---------------------------------------------------------------------------
// gffa_dp
// Datapath: occupancy column store, column pass engine (scan, check, mark),
// free-run counters with window search, result and response registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gffa_dp #(
   parameter int MAX_COLUMNS = gffa_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gffa_pkg::DEF_MAX_ROWS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_fire,
   input  wire logic [gffa_pkg::REQ_DATA_W-1:0]  req_data,
   input  wire logic                             csr_we,
   input  wire logic [gffa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gffa_pkg::CFG_W-1:0]       csr_data,
   input  wire gffa_pkg::cmd_type                cmd,
   output gffa_pkg::status_type                  status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [gffa_pkg::RSP_DATA_W-1:0]       rsp_data
);
   import gffa_pkg::*;

   localparam int ADDR_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int COL_W    = $clog2(MAX_COLUMNS + 48);
   localparam int ROW_W    = $clog2(MAX_ROWS + 48);
   localparam int ROWIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // request fields
   func_type             func_ff;
   logic [SIZE_W-1:0]    width_ff;
   logic [SIZE_W-1:0]    height_ff;
   logic [PIVOT_W-1:0]   px_ff;
   logic [PIVOT_W-1:0]   py_ff;

   logic [CFG_W-1:0]     grid_width_ff;
   logic [CFG_W-1:0]     grid_height_ff;

   logic [COL_W-1:0]     cols;
   logic [ROW_W-1:0]     rows;

   // occupancy store
   logic [MAX_ROWS-1:0]  occ_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] col_valid_ff;

   // pass engine
   op_type               op_ff;
   logic [COL_W-1:0]     ptr_ff;
   logic [COL_W-1:0]     end_ff;
   logic [ROW_W-1:0]     y0_ff;
   logic                 rvld_ff;
   logic [COL_W-1:0]     rcol_ff;
   logic [MAX_ROWS-1:0]  rdata_ff;
   logic                 runvld_ff;
   logic [COL_W-1:0]     runcol_ff;
   logic [SIZE_W-1:0]    run_ff [MAX_ROWS];
   logic [MAX_ROWS-1:0]  acc_ff;
   logic                 found_ff;

   logic                 active;
   logic                 issue;
   logic                 pass_done;
   logic                 write_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [MAX_ROWS-1:0]  wdata;
   logic [MAX_ROWS-1:0]  mark_mask;
   logic [ROW_W-1:0]     mark_top;

   logic [COL_W-1:0]     src_x;
   logic [ROW_W-1:0]     src_y;
   logic [COL_W-1:0]     span_end;

   logic [MAX_ROWS-1:0]  free_vec;
   logic [MAX_ROWS-1:0]  height_mask;
   logic [MAX_ROWS-1:0]  hit;
   logic [ROWIDX_W-1:0]  hit_row;
   logic                 found_now;

   // result and response
   logic                 res_ok_ff;
   logic [COL_W-1:0]     res_x_ff;
   logic [ROW_W-1:0]     res_y_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_ok_ff;
   logic [PIVOT_W-1:0]   rsp_x_ff;
   logic [PIVOT_W-1:0]   rsp_y_ff;

   // effective grid size
   assign cols = (COL_W'(grid_width_ff) > COL_W'(MAX_COLUMNS)) ?
                 COL_W'(MAX_COLUMNS) : COL_W'(grid_width_ff);
   assign rows = (ROW_W'(grid_height_ff) > ROW_W'(MAX_ROWS)) ?
                 ROW_W'(MAX_ROWS) : ROW_W'(grid_height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data;
            default:         grid_width_ff  <= grid_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff   <= func_type'(req_data[1:0]);
         width_ff  <= req_data[6:2];
         height_ff <= req_data[11:7];
         px_ff     <= req_data[15:12];
         py_ff     <= req_data[19:16];
      end
   end

   // pass control
   assign active    = (op_ff != OP_NONE);
   assign issue     = active && (ptr_ff < end_ff) && !found_now;
   assign pass_done = (ptr_ff >= end_ff) && !rvld_ff && !runvld_ff;
   assign write_en  = rvld_ff && ((op_ff == OP_SET) || (op_ff == OP_CLEAR));
   assign rd_addr   = ptr_ff[ADDR_W-1:0];
   assign wr_addr   = rcol_ff[ADDR_W-1:0];
   assign wdata     = (op_ff == OP_SET) ? (rdata_ff | mark_mask) : (rdata_ff & ~mark_mask);

   assign src_x    = cmd.src_pivot ? COL_W'(px_ff) : res_x_ff;
   assign src_y    = cmd.src_pivot ? ROW_W'(py_ff) : res_y_ff;
   assign span_end = src_x + COL_W'(width_ff);
   assign mark_top = y0_ff + ROW_W'(height_ff);

   always_comb begin
      for (int y = 0; y < MAX_ROWS; y++) begin
         mark_mask[y] = (ROW_W'(y) >= y0_ff) && (ROW_W'(y) < mark_top) &&
                        (ROW_W'(y) < rows);
      end
   end

   // window search over the free-run counters
   always_comb begin
      for (int k = 0; k < MAX_ROWS; k++) begin
         height_mask[k] = (ROW_W'(k) < ROW_W'(height_ff));
      end
      for (int y = 0; y < MAX_ROWS; y++) begin
         free_vec[y] = (run_ff[y] >= width_ff) && (ROW_W'(y) < rows);
      end
      for (int y = 0; y < MAX_ROWS; y++) begin
         hit[y] = (ROW_W'(height_ff) <= ROW_W'(MAX_ROWS - y)) &&
                  (&((free_vec >> y) | ~height_mask));
      end
      hit_row = '0;
      for (int y = MAX_ROWS - 1; y >= 0; y--) begin
         if (hit[y]) begin
            hit_row = ROWIDX_W'(y);
         end
      end
   end

   assign found_now = runvld_ff && (op_ff == OP_SCAN) && (|hit);

   // column store
   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= col_valid_ff[rd_addr] ? occ_mem[rd_addr] : '0;
      end
      if (write_en) begin
         occ_mem[wr_addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
      end else if (write_en) begin
         col_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_NONE;
         rvld_ff   <= 1'b0;
         runvld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else if (cmd.start) begin
         op_ff     <= cmd.op;
         rvld_ff   <= 1'b0;
         runvld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         rvld_ff   <= issue;
         runvld_ff <= rvld_ff && (op_ff == OP_SCAN);
         if (found_now) begin
            op_ff    <= OP_NONE;
            found_ff <= 1'b1;
         end else if (active && pass_done) begin
            op_ff <= OP_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ptr_ff <= (cmd.op == OP_SCAN) ? '0 : src_x;
         end_ff <= ((cmd.op == OP_SCAN) || (span_end > cols)) ? cols : span_end;
         y0_ff  <= src_y;
         acc_ff <= '0;
         for (int y = 0; y < MAX_ROWS; y++) begin
            run_ff[y] <= '0;
         end
      end else begin
         if (issue) begin
            ptr_ff  <= ptr_ff + COL_W'(1);
            rcol_ff <= ptr_ff;
         end
         if (rvld_ff && (op_ff == OP_CHECK)) begin
            acc_ff <= acc_ff | (rdata_ff & mark_mask);
         end
         if (rvld_ff && (op_ff == OP_SCAN)) begin
            runcol_ff <= rcol_ff;
            for (int y = 0; y < MAX_ROWS; y++) begin
               if (rdata_ff[y]) begin
                  run_ff[y] <= '0;
               end else if (run_ff[y] != '1) begin
                  run_ff[y] <= run_ff[y] + SIZE_W'(1);
               end
            end
         end
      end
   end

   // result
   always_ff @(posedge clock) begin
      if (found_now) begin
         res_ok_ff <= 1'b1;
         res_x_ff  <= runcol_ff - COL_W'(width_ff) + COL_W'(1);
         res_y_ff  <= ROW_W'(hit_row);
      end else if (cmd.res_pivot) begin
         res_ok_ff <= 1'b1;
         res_x_ff  <= COL_W'(px_ff);
         res_y_ff  <= ROW_W'(py_ff);
      end else if (cmd.res_clear) begin
         res_ok_ff <= 1'b0;
         res_x_ff  <= '0;
         res_y_ff  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ok_ff <= res_ok_ff;
         rsp_x_ff  <= res_x_ff[PIVOT_W-1:0];
         rsp_y_ff  <= res_y_ff[PIVOT_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_y_ff, rsp_x_ff, rsp_ok_ff};

   assign status.func     = func_ff;
   assign status.bad_size = (width_ff == '0) || (height_ff == '0);
   assign status.pos_fit  = ((COL_W'(px_ff) + COL_W'(width_ff)) <= cols) &&
                            ((ROW_W'(py_ff) + ROW_W'(height_ff)) <= rows);
   assign status.busy     = active;
   assign status.found    = found_ff;
   assign status.acc_zero = (acc_ff == '0);
   assign status.rsp_busy = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hdl/gffa_ctrl.sv -----
// ---------------------------------------------------------------------------
// gffa_ctrl
// Controller: decodes each request and sequences the datapath passes
// (scan, check, mark) and the hand-over of the response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gffa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   input  wire gffa_pkg::status_type status,
   output gffa_pkg::cmd_type         cmd
);
   import gffa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_CHECK,
      ST_MARK,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   cmd_type   cmd_ff;
   logic      fire;
   logic      settled;

   assign fire    = req_valid && ready_ff;
   // datapath pass finished and no start pending
   assign settled = !cmd_ff.start && !status.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         cmd_ff   <= '0;
      end else begin
         cmd_ff <= '0;
         unique case (state_ff)
            ST_IDLE: begin
               if (fire) begin
                  state_ff <= ST_DECODE;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_DECODE: begin
               cmd_ff.res_clear <= 1'b1;
               priority if ((status.func == FUNC_FIRST_FIT) && !status.bad_size) begin
                  state_ff     <= ST_SCAN;
                  cmd_ff.start <= 1'b1;
                  cmd_ff.op    <= OP_SCAN;
               end else if ((status.func == FUNC_ADD_AT) && !status.bad_size &&
                            status.pos_fit) begin
                  state_ff         <= ST_CHECK;
                  cmd_ff.start     <= 1'b1;
                  cmd_ff.op        <= OP_CHECK;
                  cmd_ff.src_pivot <= 1'b1;
               end else if (status.func == FUNC_REMOVE) begin
                  state_ff         <= ST_MARK;
                  cmd_ff.start     <= 1'b1;
                  cmd_ff.op        <= OP_CLEAR;
                  cmd_ff.src_pivot <= 1'b1;
                  cmd_ff.res_pivot <= 1'b1;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_SCAN: begin
               if (settled) begin
                  if (status.found) begin
                     state_ff     <= ST_MARK;
                     cmd_ff.start <= 1'b1;
                     cmd_ff.op    <= OP_SET;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_CHECK: begin
               if (settled) begin
                  if (status.acc_zero) begin
                     state_ff         <= ST_MARK;
                     cmd_ff.start     <= 1'b1;
                     cmd_ff.op        <= OP_SET;
                     cmd_ff.src_pivot <= 1'b1;
                     cmd_ff.res_pivot <= 1'b1;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_MARK: begin
               if (settled) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!status.rsp_busy || rsp_ready) begin
                  state_ff        <= ST_IDLE;
                  ready_ff        <= 1'b1;
                  cmd_ff.rsp_load <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign cmd       = cmd_ff;

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.rsp_load |-> !status.rsp_busy)
      else $error("response loaded over a waiting response");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.start |-> !status.busy)
      else $error("pass started while datapath busy");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (state_ff == ST_IDLE))
      else $error("request ready outside idle");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      fire |=> (state_ff == ST_DECODE) && !ready_ff)
      else $error("accepted request not decoded");

endmodule

`default_nettype wire

// ----- hdl/grid_rectangle_first_fit_allocator_core.sv -----
// ---------------------------------------------------------------------------
// grid_rectangle_first_fit_allocator_core
// Rectangle allocator over an occupancy grid with first-fit placement.
//
// req_*: one request per handshake (first-fit add, add at pivot, remove at
//   pivot, no-op). One request is in work at a time; req_tready is high
//   only while the block is free for a new request.
// rsp_*: exactly one response per request (ok, place_x, place_y), held in
//   an output register until taken. A stalled receiver does not stop the
//   next request being accepted; that request then waits at its end until
//   the held response is taken.
// csr_*: grid_width (index 0) and grid_height (index 1), always ready; the
//   user must write them only while no request is in work; not enforced.
// The response is loaded as the block turns ready for the next request.
//   First-fit add scans the columns and then marks the cells found; a
//   positioned add checks its cells and marks them when free; remove
//   clears its cells; bad size, out of bounds or no-op go straight to
//   the response. While a pass runs, one column is read per cycle.
// Reset frees all cells at once (per-column valid flags) and loads the
//   grid size 10 x 8; req_tready is registered and rises once reset is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_rectangle_first_fit_allocator_core #(
   parameter int MAX_COLUMNS = gffa_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gffa_pkg::DEF_MAX_ROWS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // func, item_width, item_height, pivot_x, pivot_y
   input  wire logic [gffa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // ok, place_x, place_y
   output logic [gffa_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gffa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gffa_pkg::CFG_W-1:0]       csr_data
);
   import gffa_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready;
   logic       req_fire;

   assign req_tready = ready;
   assign req_fire   = req_tvalid && ready;
   assign csr_ready  = 1'b1;

   gffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (ready),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   gffa_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_data  (req_tdata),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire
